### src/assert_macros.svh
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// prop must hold at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk_sig, rst_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) else $error(msg);

// cond must never be true outside reset
`define ASSERT_NEVER(lbl, clk_sig, rst_sig, cond, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk_sig, rst_sig, prop, msg)
`define ASSERT_NEVER(lbl, clk_sig, rst_sig, cond, msg)

`endif

`endif

### src/sqmm_pkg.sv
package sqmm_pkg;

    // Fixed field widths
    localparam int ROW_W      = 5;
    localparam int VALUE_W    = 16;
    localparam int ACC_W      = 38;
    localparam int CFG_W      = 6;
    // Wide enough for any size up to 64 and for row/col compares
    localparam int SIZE_EXT_W = 7;
    localparam logic [CFG_W-1:0] SIZE_RESET = 6'd32;

    typedef enum logic [1:0] {
        MODE_WR_A = 2'd0,
        MODE_WR_B = 2'd1,
        MODE_RD   = 2'd2
    } mode_t;

    typedef struct packed {
        mode_t                     mode;
        logic [ROW_W-1:0]          row;
        logic [ROW_W-1:0]          col;
        logic signed [VALUE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] product_value;
        logic [ROW_W-1:0]        out_row;
        logic [ROW_W-1:0]        out_col;
        logic                    index_error;
    } result_t;

    // Controller to datapath
    typedef struct packed {
        logic wr_a;
        logic wr_b;
        logic load;
        logic issue;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic err_in;
        logic last;
    } dp_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

endpackage

### src/sqmm_datapath.sv
module sqmm_datapath #(
    parameter int MAX_SIZE     = 32,
    parameter int ELEMENT_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sqmm_pkg::CFG_W-1:0]    cfg_data,
    input  sqmm_pkg::in_item_t            item,
    input  sqmm_pkg::dp_cmd_t             cmd,
    output sqmm_pkg::dp_stat_t            stat,
    output sqmm_pkg::result_t             result
);
    import sqmm_pkg::*;

    localparam int DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int EB    = ELEMENT_BITS;
    localparam int PW    = 2 * ELEMENT_BITS;
    // address arithmetic width, covers row*MAX_SIZE+col for any size
    localparam int XW    = 14;

    logic [CFG_W-1:0]         size_reg;
    logic [SIZE_EXT_W-1:0]    eff_n;
    logic [SIZE_EXT_W-1:0]    row_ext;
    logic [SIZE_EXT_W-1:0]    col_ext;
    logic                     in_store;
    logic [XW-1:0]            wr_wide;
    logic [XW-1:0]            rda_wide;
    logic [XW-1:0]            rdb_wide;
    logic signed [EB-1:0]     elem_in;

    logic signed [EB-1:0]     left_mem  [DEPTH];
    logic signed [EB-1:0]     right_mem [DEPTH];

    logic [ROW_W-1:0]         row_reg;
    logic [ROW_W-1:0]         col_reg;
    logic                     err_reg;
    logic [IW-1:0]            k_reg;
    logic signed [EB-1:0]     a_reg;
    logic signed [EB-1:0]     b_reg;
    logic                     rd_vld_reg;
    logic signed [PW-1:0]     prod_reg;
    logic                     mul_vld_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    // Size register; its effective value is saturated to the store dimension
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            size_reg <= cfg_data;
        end
    end

    always_comb
    begin
        eff_n = (SIZE_EXT_W'(size_reg) > SIZE_EXT_W'(MAX_SIZE)) ?
                SIZE_EXT_W'(MAX_SIZE) : SIZE_EXT_W'(size_reg);
    end

    // Index checks on the incoming item
    assign row_ext     = SIZE_EXT_W'(item.row);
    assign col_ext     = SIZE_EXT_W'(item.col);
    assign stat.err_in = (row_ext >= eff_n) || (col_ext >= eff_n);
    assign in_store    = (row_ext < SIZE_EXT_W'(MAX_SIZE)) &&
                         (col_ext < SIZE_EXT_W'(MAX_SIZE));
    assign stat.last   = (SIZE_EXT_W'(k_reg) + SIZE_EXT_W'(1)) == eff_n;

    // Row-major addresses
    assign wr_wide  = XW'(item.row) * XW'(MAX_SIZE) + XW'(item.col);
    assign rda_wide = XW'(row_reg) * XW'(MAX_SIZE) + XW'(k_reg);
    assign rdb_wide = XW'(k_reg) * XW'(MAX_SIZE) + XW'(col_reg);
    assign elem_in  = EB'(item.value);

    // Element stores: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (cmd.wr_a && in_store)
        begin
            left_mem[wr_wide[AW-1:0]] <= elem_in;
        end
        if (cmd.wr_b && in_store)
        begin
            right_mem[wr_wide[AW-1:0]] <= elem_in;
        end
        if (cmd.issue)
        begin
            a_reg <= left_mem[rda_wide[AW-1:0]];
            b_reg <= right_mem[rdb_wide[AW-1:0]];
        end
    end

    // Query bookkeeping and pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg  <= 1'b0;
            mul_vld_reg <= 1'b0;
            k_reg       <= '0;
        end
        else
        begin
            rd_vld_reg  <= cmd.issue;
            mul_vld_reg <= rd_vld_reg;
            if (cmd.load)
            begin
                k_reg <= '0;
            end
            else if (cmd.issue)
            begin
                k_reg <= k_reg + IW'(1);
            end
        end
    end

    // Query echo fields
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            row_reg <= item.row;
            col_reg <= item.col;
            err_reg <= stat.err_in;
        end
    end

    // Multiply, then accumulate
    always_ff @(posedge clk)
    begin
        prod_reg <= a_reg * b_reg;
        if (cmd.load)
        begin
            acc_reg <= '0;
        end
        else if (mul_vld_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign result.product_value = err_reg ? '0 : acc_reg;
    assign result.out_row       = row_reg;
    assign result.out_col       = col_reg;
    assign result.index_error   = err_reg;

endmodule

### src/sqmm_ctrl.sv
`include "assert_macros.svh"

module sqmm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  sqmm_pkg::mode_t       mode,
    input  sqmm_pkg::dp_stat_t    stat,
    output sqmm_pkg::dp_cmd_t     cmd,
    output logic                  busy,
    output logic                  done
);
    import sqmm_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   drain_reg;
    logic   drain_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            drain_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            drain_reg <= drain_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        drain_next = drain_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    unique case (mode)
                        MODE_WR_A: cmd.wr_a = 1'b1;
                        MODE_WR_B: cmd.wr_b = 1'b1;
                        MODE_RD:
                        begin
                            cmd.load   = 1'b1;
                            state_next = stat.err_in ? ST_DONE : ST_RUN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
                if (stat.last)
                begin
                    state_next = ST_DRAIN;
                    drain_next = 1'b0;
                end
            end
            ST_DRAIN:
            begin
                // read and multiply stages empty out
                if (drain_reg)
                begin
                    state_next = ST_DONE;
                end
                drain_next = 1'b1;
            end
            ST_DONE:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ASSERT_CLK(a_done_one_cycle, clk, rst_n, done |=> !done, "done held for more than one cycle")
    `ASSERT_CLK(a_err_no_walk, clk, rst_n, (cmd.load && stat.err_in) |=> done, "index error query walked")
    `ASSERT_CLK(a_drain_to_done, clk, rst_n, (state_reg == ST_DRAIN && drain_reg) |=> done, "drain did not end in done")
    `ASSERT_NEVER(a_issue_while_idle, clk, rst_n, cmd.issue && !busy, "issue while idle")

endmodule

### src/square_matrix_multiply.sv
// An element write is taken in its accept cycle, one item per cycle while idle.
// A product query walks n terms (n = effective size), drains the read and
// multiply stages, then strobes done and returns to idle for the next accept.
// An index error query returns its result in the cycle after accept.
// The walk does one multiply-accumulate per cycle through one read port per store.
// Reset clears the controller and sets the size to 32; store contents are unknown.
module square_matrix_multiply #(
    parameter int MAX_SIZE     = 32,
    parameter int ELEMENT_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sqmm_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          start,
    input  sqmm_pkg::in_item_t            item,
    output logic                          busy,
    output logic                          done,
    output sqmm_pkg::result_t             result
);
    import sqmm_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer
    sqmm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (item.mode),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Stores, multiply-accumulate and size register
    sqmm_datapath #(
        .MAX_SIZE     (MAX_SIZE),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .item     (item),
        .cmd      (cmd),
        .stat     (stat),
        .result   (result)
    );

endmodule
